// File: src/dcd_pkg.sv
package dcd_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned OMEGA_W     = 9;
  localparam int unsigned NUM_W       = 16;
  localparam int unsigned NUM_LANES   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAN_W-1:0]  ATMOS_LIMIT_RST = 8'd240;
  localparam logic [OMEGA_W-1:0] OMEGA_Q_RST     = 9'd243;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    REG_ATMOS_LIMIT = 1'b0,
    REG_OMEGA_Q     = 1'b1
  } reg_idx_t;

  // pixel kinds
  localparam logic KIND_ANALYZE = 1'b0;
  localparam logic KIND_CORRECT = 1'b1;

  // one correction request passed from front to back
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              last;
    logic [CHAN_W-1:0] atmos;
    logic [CHAN_W-1:0] trans;
  } job_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } back_state_t;

  // apply sign to the quotient magnitude, add A, clamp to 0..255
  function automatic logic [CHAN_W-1:0] sat_channel(
    input logic [NUM_W-1:0]  quo,
    input logic              neg,
    input logic [CHAN_W-1:0] atmos
  );
    logic signed [NUM_W+1:0] qs;
    logic signed [NUM_W+1:0] v;
    qs = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    v  = qs + $signed({{(NUM_W+2-CHAN_W){1'b0}}, atmos});
    if (v < 0) begin
      return '0;
    end else if (v > $signed({{(NUM_W+2-CHAN_W){1'b0}}, {CHAN_W{1'b1}}})) begin
      return {CHAN_W{1'b1}};
    end else begin
      return v[CHAN_W-1:0];
    end
  endfunction

endpackage

// File: src/dark_channel_dehaze_core.sv
// Dark channel dehaze core.
// Input channel (in_valid/in_ready): one BGR pixel per request with kind and
// last. The frame is sent twice: kind 0 pixels build the atmospheric light
// estimate (last latches it), kind 1 pixels are corrected and each gives one
// result on the output channel (out_valid/out_ready), with out_last copied.
// Analysis pixels give no result and are taken one per cycle while in_ready
// is high. A correction pixel goes to a short queue, then through a 16-step
// restoring divider (one quotient bit per cycle, three channels in
// parallel): it is popped from the queue, the 16 divide steps run, and the
// result is loaded into the output register with out_valid. The back end
// takes no new pixel from the queue until that result is loaded.
// in_ready drops only while the queue is full; a stalled receiver holds the
// result in the output register, then the divider, then fills the queue.
// The user writes configuration (cfg_we/cfg_index/cfg_data) while the core
// idles only; the core does not enforce this. Reset (rst, synchronous) sets
// atmos_limit=240, omega_q=243, clears running max, atmos light, queue, output.
module dark_channel_dehaze_core #(
  parameter int unsigned QDEPTH = dcd_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [dcd_pkg::CHAN_W-1:0]  blue,
  input  logic [dcd_pkg::CHAN_W-1:0]  green,
  input  logic [dcd_pkg::CHAN_W-1:0]  red,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dcd_pkg::CHAN_W-1:0]  out_blue,
  output logic [dcd_pkg::CHAN_W-1:0]  out_green,
  output logic [dcd_pkg::CHAN_W-1:0]  out_red,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [dcd_pkg::OMEGA_W-1:0] cfg_data
);
  import dcd_pkg::*;

  logic [CHAN_W-1:0]  atmos_limit;
  logic [OMEGA_W-1:0] omega_q;
  logic               accept;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  job_t               job_in;
  job_t               job_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      atmos_limit <= ATMOS_LIMIT_RST;
      omega_q     <= OMEGA_Q_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ATMOS_LIMIT: atmos_limit <= cfg_data[CHAN_W-1:0];
        REG_OMEGA_Q:     omega_q     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  dcd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (kind),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .last        (last),
    .atmos_limit (atmos_limit),
    .omega_q     (omega_q),
    .push        (push),
    .job         (job_in)
  );

  dcd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (job_in),
    .pop     (pop),
    .rd_data (job_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  dcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (job_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .out_last  (out_last)
  );

endmodule

// File: src/dcd_front.sv
module dcd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          kind,
  input  logic [dcd_pkg::CHAN_W-1:0]    blue,
  input  logic [dcd_pkg::CHAN_W-1:0]    green,
  input  logic [dcd_pkg::CHAN_W-1:0]    red,
  input  logic                          last,
  input  logic [dcd_pkg::CHAN_W-1:0]    atmos_limit,
  input  logic [dcd_pkg::OMEGA_W-1:0]   omega_q,
  output logic                          push,
  output dcd_pkg::job_t                 job
);
  import dcd_pkg::*;

  logic [CHAN_W-1:0]          running_max;
  logic [CHAN_W-1:0]          atmos_light;
  logic [CHAN_W-1:0]          dark;
  logic [CHAN_W-1:0]          max_new;
  logic [OMEGA_W+CHAN_W-1:0]  prod;
  logic [CHAN_W:0]            scaled;
  logic [CHAN_W:0]            t_raw;

  // dark value: min of three channels
  always_comb begin
    dark = (blue < green) ? blue : green;
    if (red < dark) dark = red;
    max_new = (dark > running_max) ? dark : running_max;
  end

  // transmission: 255 - round(omega*dark/256), at least 1
  always_comb begin
    prod   = OMEGA_W'(omega_q) * (OMEGA_W+CHAN_W)'(dark);
    scaled = (CHAN_W+1)'((prod + (OMEGA_W+CHAN_W)'(128)) >> CHAN_W);
    t_raw  = (CHAN_W+1)'(255) - scaled;
    job.blue  = blue;
    job.green = green;
    job.red   = red;
    job.last  = last;
    job.atmos = atmos_light;
    if (scaled >= (CHAN_W+1)'(255)) begin
      job.trans = CHAN_W'(1);
    end else begin
      job.trans = t_raw[CHAN_W-1:0];
    end
    push = accept && (kind == KIND_CORRECT);
  end

  // analysis statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
      atmos_light <= '0;
    end else if (accept && kind == KIND_ANALYZE) begin
      if (last) begin
        atmos_light <= (atmos_limit < max_new) ? atmos_limit : max_new;
        running_max <= '0;
      end else begin
        running_max <= max_new;
      end
    end
  end

endmodule

// File: src/dcd_queue.sv
module dcd_queue #(
  parameter int unsigned DEPTH = dcd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dcd_pkg::job_t wr_data,
  input  logic          pop,
  output dcd_pkg::job_t rd_data,
  output logic          full,
  output logic          empty
);
  import dcd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty)) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

// File: src/dcd_back.sv
module dcd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  dcd_pkg::job_t              q_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dcd_pkg::CHAN_W-1:0] out_blue,
  output logic [dcd_pkg::CHAN_W-1:0] out_green,
  output logic [dcd_pkg::CHAN_W-1:0] out_red,
  output logic                       out_last
);
  import dcd_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [3:0]        cnt;
  logic [CHAN_W-1:0] atmos;
  logic [CHAN_W-1:0] trans;
  logic              last_r;
  logic              load_out;
  logic [CHAN_W-1:0] chan     [NUM_LANES];
  logic [NUM_W-1:0]  quo      [NUM_LANES];
  logic [CHAN_W-1:0] rem      [NUM_LANES];
  logic              neg      [NUM_LANES];
  logic [CHAN_W-1:0] res      [NUM_LANES];

  assign chan[0] = q_data.blue;
  assign chan[1] = q_data.green;
  assign chan[2] = q_data.red;

  // sequencer
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == 4'd15) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) cnt <= cnt + 1'b1;
      else                cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      atmos  <= q_data.atmos;
      trans  <= q_data.trans;
      last_r <= q_data.last;
    end
  end

  // one restoring divider per channel, one quotient bit per cycle
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    logic [CHAN_W:0]   diff;
    logic [CHAN_W-1:0] mag;
    logic [CHAN_W:0]   rem_sh;
    logic              ge;

    always_comb begin
      diff   = {1'b0, chan[i]} - {1'b0, q_data.atmos};
      mag    = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
      rem_sh = {rem[i], quo[i][NUM_W-1]};
      ge     = (rem_sh >= {1'b0, trans});
      res[i] = sat_channel(quo[i], neg[i], atmos);
    end

    always_ff @(posedge clk) begin
      if (pop) begin
        // numerator magnitude = 255 * |c - A|
        quo[i] <= {mag, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, mag};
        rem[i] <= '0;
        neg[i] <= diff[CHAN_W];
      end else if (state == S_DIV) begin
        rem[i] <= ge ? CHAN_W'(rem_sh - {1'b0, trans}) : rem_sh[CHAN_W-1:0];
        quo[i] <= {quo[i][NUM_W-2:0], ge};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_blue  <= res[0];
      out_green <= res[1];
      out_red   <= res[2];
      out_last  <= last_r;
    end
  end

  a_trans_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (trans != '0)) else $error("divide by zero");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == 4'd15) |=> (state == S_HOLD))
    else $error("divider did not finish after 16 steps");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready)) else $error("result overwritten");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == S_IDLE && !q_empty)) else $error("pop outside idle");

endmodule
